>>> rtl/gvr_pkg.sv
`default_nettype none

package gvr_pkg;

    localparam int DEF_MAX_ARCH_TAPS  = 2;
    localparam int DEF_MAX_GARCH_TAPS = 2;
    localparam int NUM_COEF           = 2;

    localparam int INNOV_W  = 16;
    localparam int VALUE_W  = 28;
    localparam int VAR_W    = 32;
    localparam int BASE_W   = 24;
    localparam int COEF_W   = 16;
    localparam int ORDER_W  = 2;
    localparam int WARMUP_W = 16;
    localparam int INDEX_W  = 17;
    localparam int FRAC_W   = 16;
    localparam int E_FRAC_W = 12;
    localparam int ROOT_W   = 24;
    localparam int SQ_W     = 2 * VALUE_W - FRAC_W;
    localparam int DROP_W   = WARMUP_W + 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 64;

    localparam logic [VAR_W-1:0]   ONE_Q16   = 32'h0001_0000;
    localparam logic [INDEX_W-1:0] INDEX_MAX = '1;
    localparam logic [ORDER_W-1:0] ORDER_CAP = 2'd2;

    localparam logic [BASE_W-1:0]   RST_BASE_VARIANCE = 24'd6554;
    localparam logic [COEF_W-1:0]   RST_ARCH_COEF_ONE  = 16'd6554;
    localparam logic [COEF_W-1:0]   RST_ARCH_COEF_TWO  = 16'd0;
    localparam logic [COEF_W-1:0]   RST_GARCH_COEF_ONE = 16'd52429;
    localparam logic [COEF_W-1:0]   RST_GARCH_COEF_TWO = 16'd0;
    localparam logic [ORDER_W-1:0]  RST_ARCH_ORDER     = 2'd1;
    localparam logic [ORDER_W-1:0]  RST_GARCH_ORDER    = 2'd1;
    localparam logic [WARMUP_W-1:0] RST_WARMUP_LENGTH  = 16'd1000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BASE_VARIANCE  = 3'd0,
        CFG_ARCH_COEF_ONE  = 3'd1,
        CFG_ARCH_COEF_TWO  = 3'd2,
        CFG_GARCH_COEF_ONE = 3'd3,
        CFG_GARCH_COEF_TWO = 3'd4,
        CFG_ARCH_ORDER     = 3'd5,
        CFG_GARCH_ORDER    = 3'd6,
        CFG_WARMUP_LENGTH  = 3'd7
    } cfg_idx_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL1  = 6'b000010,
        S_MUL2  = 6'b000100,
        S_ROOT  = 6'b001000,
        S_SCALE = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [VAR_W-1:0]   variance_t;
    typedef logic [COEF_W-1:0]  coef_t;

endpackage

`default_nettype wire

>>> rtl/garch_volatility_recursion.sv
// GARCH(q,p) volatility recursion. Each input transfer carries one Q4.12 innovation
// sample; from sample index max(q,p) on, the block forms the Q16.16 conditional
// variance from the base term, the squared past values and the past variances,
// saturates it, and scales the innovation by its square root to give the Q12.16
// process value. The first warmup_length+q+p samples of a run give no output
// transfer; a sample with tlast set ends the run and clears the history. The work
// is serial: squaring and weighting use radix-4 shift-add multipliers (two bits per
// clock), the root is a bit-serial unit giving one root bit per clock. An active
// sample holds ready low from its input transfer on, through the chain of
// 14 squaring steps, an 8-step weighting multiply, the 24-step root and an 8-step
// scaling multiply, so no new sample is taken before the previous one is done. A
// sample before index max(q,p) holds ready low for one clock. A finished result
// sits in the output register while the next sample is worked on; a further
// result waits in the completion step, with ready low, until the previous one
// has been transferred. Registers may be written only while no sample is in
// flight.
`default_nettype none

module garch_volatility_recursion
    import gvr_pkg::*;
#(
    parameter int MAX_ARCH_TAPS  = DEF_MAX_ARCH_TAPS,
    parameter int MAX_GARCH_TAPS = DEF_MAX_GARCH_TAPS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // innovation [15:0]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // process_value [27:0], variance_value [59:28], zero [63:60]
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tlast
);

    localparam int ACC_W = VAR_W + 2;
    localparam int TOT_W = SQ_W + 2;

    state_t state_reg, state_next;

    logic [BASE_W-1:0]   base_variance_reg;
    coef_t               arch_coef_reg  [NUM_COEF];
    coef_t               garch_coef_reg [NUM_COEF];
    logic [ORDER_W-1:0]  arch_order_reg, garch_order_reg;
    logic [WARMUP_W-1:0] warmup_length_reg;

    value_t              value_hist_reg [MAX_ARCH_TAPS];
    variance_t           var_hist_reg   [MAX_GARCH_TAPS];
    logic [INDEX_W-1:0]  index_reg;

    logic [INNOV_W-1:0]  innov_reg;
    logic                last_reg;
    logic                emit_reg;
    variance_t           var_reg;
    value_t              val_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic                root_pend_reg;

    logic                m_valid_reg;
    value_t              m_value_reg;
    variance_t           m_var_reg;
    logic                m_last_reg;

    logic [ORDER_W-1:0]  q_lim, p_lim, q_eff, p_eff, first_active_idx;
    logic [DROP_W-1:0]   drop_idx;
    logic                in_fire, active_in, emit_in;
    logic                out_free, out_load, done_fire;
    logic                mul1_start, mul2_start, root_start, scale_start;

    logic [MAX_ARCH_TAPS-1:0]  sq_busy, at_busy;
    logic [MAX_GARCH_TAPS-1:0] gt_busy;
    logic [SQ_W-1:0]           arch_term  [MAX_ARCH_TAPS];
    logic [VAR_W-1:0]          garch_term [MAX_GARCH_TAPS];
    logic [ACC_W-1:0]          garch_sum;
    logic [TOT_W-1:0]          total_sum;
    variance_t                 var_sat;

    logic                    root_busy, scale_busy;
    logic [ROOT_W-1:0]       root;
    logic [INNOV_W-1:0]      e_mag;
    logic [ROOT_W+INNOV_W-1:0] scale_prod;
    value_t                  scaled, val_signed;

    // Order limits: a code of three reads as two, then the tap count caps it.
    always_comb begin
        q_lim = (arch_order_reg > ORDER_CAP) ? ORDER_CAP : arch_order_reg;
        p_lim = (garch_order_reg > ORDER_CAP) ? ORDER_CAP : garch_order_reg;
        q_eff = (q_lim > ORDER_W'(MAX_ARCH_TAPS)) ? ORDER_W'(MAX_ARCH_TAPS) : q_lim;
        p_eff = (p_lim > ORDER_W'(MAX_GARCH_TAPS)) ? ORDER_W'(MAX_GARCH_TAPS) : p_lim;
        first_active_idx = (q_eff > p_eff) ? q_eff : p_eff;
        drop_idx  = DROP_W'(warmup_length_reg) + DROP_W'(q_eff) + DROP_W'(p_eff);
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign active_in = (index_reg >= INDEX_W'(first_active_idx));
    assign emit_in   = ({1'b0, index_reg} >= drop_idx);
    assign out_free  = !m_valid_reg || m_tready;

    for (genvar i = 0; i < MAX_ARCH_TAPS; i++) begin : g_arch
        value_t                mag;
        logic [2*VALUE_W-1:0]  sq_prod;
        logic [SQ_W+COEF_W-1:0] at_prod;

        assign mag = value_hist_reg[i][VALUE_W-1] ? (~value_hist_reg[i] + 1'b1)
                                                  : value_hist_reg[i];

        gvr_serial_mul #(.A_W(VALUE_W), .B_W(VALUE_W)) u_square (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (mul1_start),
            .a       (mag),
            .b       (mag),
            .busy    (sq_busy[i]),
            .product (sq_prod)
        );

        gvr_serial_mul #(.A_W(SQ_W), .B_W(COEF_W)) u_weight (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (mul2_start),
            .a       (sq_prod[2*VALUE_W-1:FRAC_W]),
            .b       (arch_coef_reg[i]),
            .busy    (at_busy[i]),
            .product (at_prod)
        );

        assign arch_term[i] = (q_eff > ORDER_W'(i)) ? at_prod[SQ_W+COEF_W-1:FRAC_W] : '0;
    end

    for (genvar j = 0; j < MAX_GARCH_TAPS; j++) begin : g_garch
        logic [VAR_W+COEF_W-1:0] gt_prod;

        gvr_serial_mul #(.A_W(VAR_W), .B_W(COEF_W)) u_weight (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (mul1_start),
            .a       (var_hist_reg[j]),
            .b       (garch_coef_reg[j]),
            .busy    (gt_busy[j]),
            .product (gt_prod)
        );

        assign garch_term[j] = (p_eff > ORDER_W'(j)) ? gt_prod[VAR_W+COEF_W-1:FRAC_W] : '0;
    end

    always_comb begin
        garch_sum = ACC_W'(base_variance_reg);
        for (int k = 0; k < MAX_GARCH_TAPS; k++) begin
            garch_sum = garch_sum + ACC_W'(garch_term[k]);
        end
        total_sum = TOT_W'(acc_reg);
        for (int k = 0; k < MAX_ARCH_TAPS; k++) begin
            total_sum = total_sum + TOT_W'(arch_term[k]);
        end
        var_sat = (|total_sum[TOT_W-1:VAR_W]) ? '1 : total_sum[VAR_W-1:0];
    end

    gvr_isqrt #(.ROOT_W(ROOT_W)) u_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand ({var_reg, {FRAC_W{1'b0}}}),
        .busy     (root_busy),
        .root     (root)
    );

    assign e_mag = innov_reg[INNOV_W-1] ? (~innov_reg + 1'b1) : innov_reg;

    gvr_serial_mul #(.A_W(ROOT_W), .B_W(INNOV_W)) u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scale_start),
        .a       (root),
        .b       (e_mag),
        .busy    (scale_busy),
        .product (scale_prod)
    );

    assign scaled     = scale_prod[ROOT_W+INNOV_W-1:E_FRAC_W];
    assign val_signed = innov_reg[INNOV_W-1] ? (~scaled + 1'b1) : scaled;

    always_comb begin
        state_next  = state_reg;
        mul1_start  = 1'b0;
        mul2_start  = 1'b0;
        scale_start = 1'b0;
        done_fire   = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (active_in) begin
                        mul1_start = 1'b1;
                        state_next = S_MUL1;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MUL1: begin
                if (!(|sq_busy) && !(|gt_busy)) begin
                    mul2_start = 1'b1;
                    state_next = S_MUL2;
                end
            end
            S_MUL2: begin
                if (!(|at_busy)) begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT: begin
                if (!root_busy && !root_pend_reg) begin
                    scale_start = 1'b1;
                    state_next  = S_SCALE;
                end
            end
            S_SCALE: begin
                if (!scale_busy) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!emit_reg || out_free) begin
                    done_fire  = 1'b1;
                    out_load   = emit_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // The root starts in the cycle after the saturated variance is registered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            root_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            root_pend_reg <= (state_reg == S_MUL2) && !(|at_busy);
        end
    end

    assign root_start = root_pend_reg;

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            innov_reg <= s_tdata[INNOV_W-1:0];
            last_reg  <= s_tlast;
            emit_reg  <= emit_in;
            var_reg   <= ONE_Q16;
            val_reg   <= '0;
        end
        if (mul2_start) begin
            acc_reg <= garch_sum;
        end
        if (state_reg == S_MUL2 && !(|at_busy)) begin
            var_reg <= var_sat;
        end
        if (state_reg == S_SCALE && !scale_busy) begin
            val_reg <= val_signed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_ARCH_TAPS; k++) begin
                value_hist_reg[k] <= '0;
            end
            for (int k = 0; k < MAX_GARCH_TAPS; k++) begin
                var_hist_reg[k] <= ONE_Q16;
            end
            index_reg <= '0;
        end else if (done_fire) begin
            if (last_reg) begin
                for (int k = 0; k < MAX_ARCH_TAPS; k++) begin
                    value_hist_reg[k] <= '0;
                end
                for (int k = 0; k < MAX_GARCH_TAPS; k++) begin
                    var_hist_reg[k] <= ONE_Q16;
                end
                index_reg <= '0;
            end else begin
                value_hist_reg[0] <= val_reg;
                for (int k = 1; k < MAX_ARCH_TAPS; k++) begin
                    value_hist_reg[k] <= value_hist_reg[k-1];
                end
                var_hist_reg[0] <= var_reg;
                for (int k = 1; k < MAX_GARCH_TAPS; k++) begin
                    var_hist_reg[k] <= var_hist_reg[k-1];
                end
                if (index_reg != INDEX_MAX) begin
                    index_reg <= index_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_variance_reg <= RST_BASE_VARIANCE;
            arch_coef_reg[0]  <= RST_ARCH_COEF_ONE;
            arch_coef_reg[1]  <= RST_ARCH_COEF_TWO;
            garch_coef_reg[0] <= RST_GARCH_COEF_ONE;
            garch_coef_reg[1] <= RST_GARCH_COEF_TWO;
            arch_order_reg    <= RST_ARCH_ORDER;
            garch_order_reg   <= RST_GARCH_ORDER;
            warmup_length_reg <= RST_WARMUP_LENGTH;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_BASE_VARIANCE:  base_variance_reg <= cfg_wdata[BASE_W-1:0];
                CFG_ARCH_COEF_ONE:  arch_coef_reg[0]  <= cfg_wdata[COEF_W-1:0];
                CFG_ARCH_COEF_TWO:  arch_coef_reg[1]  <= cfg_wdata[COEF_W-1:0];
                CFG_GARCH_COEF_ONE: garch_coef_reg[0] <= cfg_wdata[COEF_W-1:0];
                CFG_GARCH_COEF_TWO: garch_coef_reg[1] <= cfg_wdata[COEF_W-1:0];
                CFG_ARCH_ORDER:     arch_order_reg    <= cfg_wdata[ORDER_W-1:0];
                CFG_GARCH_ORDER:    garch_order_reg   <= cfg_wdata[ORDER_W-1:0];
                CFG_WARMUP_LENGTH:  warmup_length_reg <= cfg_wdata[WARMUP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_value_reg <= val_reg;
            m_var_reg   <= var_reg;
            m_last_reg  <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - VAR_W){1'b0}}, m_var_reg, m_value_reg};
    assign m_tlast  = m_last_reg;

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("input taken while a sample is still in flight");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("output transfer raised outside the completion step");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("result loaded over one not yet transferred");

    a_zero_variance_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_value_reg != '0)) |-> (m_var_reg != '0))
        else $error("nonzero process value with zero variance");

endmodule

`default_nettype wire

>>> rtl/gvr_serial_mul.sv
`default_nettype none

module gvr_serial_mul #(
    parameter int A_W = 16,
    parameter int B_W = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [A_W-1:0]       a,
    input  wire logic [B_W-1:0]       b,
    output logic                      busy,
    output logic [A_W+B_W-1:0]        product
);

    localparam int B_EW  = B_W + (B_W % 2);
    localparam int STEPS = B_EW / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [A_W+B_EW-1:0] acc_reg, acc_next;
    logic [A_W-1:0]      a_reg;
    logic [A_W+1:0]      a3_reg;
    logic [A_W+1:0]      multiple;
    logic [A_W+1:0]      sum;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;

    always_comb begin
        case (acc_reg[1:0])
            2'd0:    multiple = '0;
            2'd1:    multiple = {2'b00, a_reg};
            2'd2:    multiple = {1'b0, a_reg, 1'b0};
            2'd3:    multiple = a3_reg;
            default: multiple = '0;
        endcase
        sum      = {2'b00, acc_reg[A_W+B_EW-1 -: A_W]} + multiple;
        acc_next = {sum, acc_reg[B_EW-1:2]};
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= {{A_W{1'b0}}, B_EW'(b)};
            a_reg   <= a;
            a3_reg  <= {2'b00, a} + {1'b0, a, 1'b0};
        end else if (busy_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign busy    = busy_reg;
    assign product = acc_reg[A_W+B_W-1:0];

endmodule

`default_nettype wire

>>> rtl/gvr_isqrt.sv
`default_nettype none

module gvr_isqrt #(
    parameter int ROOT_W = 24
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [2*ROOT_W-1:0]   radicand,
    output logic                       busy,
    output logic [ROOT_W-1:0]          root
);

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [2*ROOT_W-1:0] rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [REM_W-1:0]    rem_sh;
    logic [REM_W:0]      trial;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;

    always_comb begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[2*ROOT_W-1 -: 2]};
        trial  = {1'b0, rem_sh} - {2'b00, root_reg, 2'b01};
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg <= {rad_reg[2*ROOT_W-3:0], 2'b00};
            if (!trial[REM_W]) begin
                rem_reg  <= trial[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

>>> bench/tb_garch_volatility_recursion.sv
`default_nettype none

module tb_garch_volatility_recursion
    import gvr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 150;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 850;
    localparam int MAX_GAP       = 18;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [VAR_W-1:0]   variance;
        logic               last;
    } garch_result_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SAMPLE,
        ROW_CHECKED
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        cfg_idx_t               reg_idx;
        logic [CFG_DATA_W-1:0]  wdata;
        logic [INNOV_W-1:0]     innov;
        logic                   last;
        garch_result_t          known;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    // innovation [15:0]
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    // process_value [27:0], variance_value [59:28], zero [63:60]
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    garch_volatility_recursion u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Register copies and recursion history of the predictor.
    logic [BASE_W-1:0]   base_var_reg;
    logic [COEF_W-1:0]   arch_w [2];
    logic [COEF_W-1:0]   garch_w [2];
    logic [ORDER_W-1:0]  arch_ord;
    logic [ORDER_W-1:0]  garch_ord;
    logic [WARMUP_W-1:0] warmup_len;

    longint unsigned var_hist [2];
    longint          val_hist [2];
    int unsigned     run_index;

    garch_result_t   expected_results [$];
    stim_row_t       directed_rows [$];
    int unsigned     errors = 0;
    bit              snd_steady = 1'b0;
    bit              rcv_steady = 1'b0;

    function automatic void clear_history();
        var_hist[0] = ONE_Q16;
        var_hist[1] = ONE_Q16;
        val_hist[0] = 0;
        val_hist[1] = 0;
        run_index   = 0;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void predict_sample(input logic [INNOV_W-1:0] innov, input logic last,
                                           output logic produced, output garch_result_t res);
        int unsigned     q;
        int unsigned     p;
        int unsigned     start;
        int unsigned     drop;
        longint unsigned acc;
        longint unsigned cvar;
        longint unsigned root;
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned prod;
        longint          e;
        longint          val;
        q = (arch_ord > ORDER_CAP) ? ORDER_CAP : arch_ord;
        if (q > DEF_MAX_ARCH_TAPS)
            q = DEF_MAX_ARCH_TAPS;
        p = (garch_ord > ORDER_CAP) ? ORDER_CAP : garch_ord;
        if (p > DEF_MAX_GARCH_TAPS)
            p = DEF_MAX_GARCH_TAPS;
        start = (q > p) ? q : p;
        drop  = warmup_len + q + p;
        cvar  = ONE_Q16;
        val   = 0;
        if (run_index >= start) begin
            acc = base_var_reg;
            for (int i = 0; i < q; i++) begin
                mag = (val_hist[i] < 0) ? -val_hist[i] : val_hist[i];
                sq  = (mag * mag) >> 16;
                acc += (sq * arch_w[i]) >> 16;
            end
            for (int i = 0; i < p; i++)
                acc += (var_hist[i] * garch_w[i]) >> 16;
            cvar = (acc > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : acc;
            root = int_sqrt(cvar << 16);
            e    = longint'($signed(innov));
            mag  = (e < 0) ? -e : e;
            prod = (mag * root) >> 12;
            val  = (e < 0) ? -longint'(prod) : longint'(prod);
        end
        var_hist[1] = var_hist[0];
        var_hist[0] = cvar;
        val_hist[1] = val_hist[0];
        val_hist[0] = val;
        produced     = (run_index >= drop);
        res.value    = val[VALUE_W-1:0];
        res.variance = cvar[VAR_W-1:0];
        res.last     = last;
        if (run_index < INDEX_MAX)
            run_index++;
        if (last)
            clear_history();
    endfunction

    function automatic void row_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] wdata);
        stim_row_t r;
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.wdata   = wdata;
        r.innov   = '0;
        r.last    = 1'b0;
        r.known   = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void row_sample(logic [INNOV_W-1:0] innov, logic last);
        stim_row_t r;
        r.kind    = ROW_SAMPLE;
        r.reg_idx = CFG_BASE_VARIANCE;
        r.wdata   = '0;
        r.innov   = innov;
        r.last    = last;
        r.known   = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void row_checked(logic [INNOV_W-1:0] innov, logic last, longint value,
                                        longint unsigned variance);
        stim_row_t r;
        r.kind           = ROW_CHECKED;
        r.reg_idx        = CFG_BASE_VARIANCE;
        r.wdata          = '0;
        r.innov          = innov;
        r.last           = last;
        r.known.value    = value[VALUE_W-1:0];
        r.known.variance = variance[VAR_W-1:0];
        r.known.last     = last;
        directed_rows.push_back(r);
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic send_sample(input logic [INNOV_W-1:0] innov, input logic last,
                               input logic has_known, input garch_result_t known);
        int unsigned   gap;
        logic          produced;
        garch_result_t res;
        gap = snd_steady ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= innov;
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_sample(innov, last, produced, res);
        if (has_known)
            expected_results.push_back(known);
        else if (produced)
            expected_results.push_back(res);
    endtask

    // Drops valid, lets every expected result arrive, then lets the block run dry.
    task automatic settle();
        int n;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        n = 0;
        while (expected_results.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
            errors++;
            expected_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] wdata);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= wdata;
        @(posedge aclk);
        case (idx)
            CFG_BASE_VARIANCE:  base_var_reg = wdata[BASE_W-1:0];
            CFG_ARCH_COEF_ONE:  arch_w[0]    = wdata[COEF_W-1:0];
            CFG_ARCH_COEF_TWO:  arch_w[1]    = wdata[COEF_W-1:0];
            CFG_GARCH_COEF_ONE: garch_w[0]   = wdata[COEF_W-1:0];
            CFG_GARCH_COEF_TWO: garch_w[1]   = wdata[COEF_W-1:0];
            CFG_ARCH_ORDER:     arch_ord     = wdata[ORDER_W-1:0];
            CFG_GARCH_ORDER:    garch_ord    = wdata[ORDER_W-1:0];
            CFG_WARMUP_LENGTH:  warmup_len   = wdata[WARMUP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [INNOV_W-1:0] draw_innovation();
        if ($urandom_range(0, 15) != 0)
            return INNOV_W'($urandom);
        case ($urandom_range(0, 3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    initial begin : stimulus
        bit          writing;
        bit          stable;
        bit          close_run;
        int unsigned random_sent;
        int unsigned runs;
        int unsigned run_len;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;

        base_var_reg = RST_BASE_VARIANCE;
        arch_w[0]    = RST_ARCH_COEF_ONE;
        arch_w[1]    = RST_ARCH_COEF_TWO;
        garch_w[0]   = RST_GARCH_COEF_ONE;
        garch_w[1]   = RST_GARCH_COEF_TWO;
        arch_ord     = RST_ARCH_ORDER;
        garch_ord    = RST_GARCH_ORDER;
        warmup_len   = RST_WARMUP_LENGTH;
        clear_history();

        // With no taps and a base of 1.0 the root is exactly 1.0, so each value is 16 * e.
        row_write(CFG_WARMUP_LENGTH, 24'd0);
        row_write(CFG_ARCH_ORDER, 24'd0);
        row_write(CFG_GARCH_ORDER, 24'd0);
        row_write(CFG_BASE_VARIANCE, 24'h01_0000);
        row_checked(16'h7FFF, 1'b0, 524272, 65536);
        row_checked(16'h8000, 1'b0, -524288, 65536);
        row_checked(16'h0000, 1'b0, 0, 65536);
        row_checked(16'hFFFF, 1'b0, -16, 65536);
        row_checked(16'h0001, 1'b1, 16, 65536);
        // Orders of 3 fold to two taps; all weights full scale drive the variance to saturation.
        row_write(CFG_ARCH_ORDER, 24'd3);
        row_write(CFG_GARCH_ORDER, 24'd3);
        row_write(CFG_BASE_VARIANCE, 24'hFF_FFFF);
        row_write(CFG_ARCH_COEF_ONE, 24'h00_FFFF);
        row_write(CFG_ARCH_COEF_TWO, 24'h00_FFFF);
        row_write(CFG_GARCH_COEF_ONE, 24'h00_FFFF);
        row_write(CFG_GARCH_COEF_TWO, 24'h00_FFFF);
        row_sample(16'h7FFF, 1'b0);
        row_sample(16'h8000, 1'b0);
        row_sample(16'h7FFF, 1'b0);
        row_sample(16'h8000, 1'b0);
        row_sample(16'h7FFF, 1'b0);
        row_sample(16'h8000, 1'b1);
        // A run that ends inside the discarded part, then a run with every weight at zero.
        row_write(CFG_ARCH_ORDER, 24'd2);
        row_write(CFG_GARCH_ORDER, 24'd1);
        row_write(CFG_BASE_VARIANCE, 24'd0);
        row_write(CFG_ARCH_COEF_ONE, 24'd0);
        row_write(CFG_ARCH_COEF_TWO, 24'd0);
        row_write(CFG_GARCH_COEF_ONE, 24'd0);
        row_write(CFG_GARCH_COEF_TWO, 24'd0);
        row_write(CFG_WARMUP_LENGTH, 24'd3);
        row_sample(16'h0064, 1'b0);
        row_sample(16'h00C8, 1'b1);
        for (int k = 0; k < 8; k++)
            row_sample(INNOV_W'(16'h1000 + k), k == 7);
        row_write(CFG_WARMUP_LENGTH, 24'h00_FFFF);
        row_sample(16'h1234, 1'b0);
        row_sample(16'hEDCC, 1'b1);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        settle();
        writing = 1'b1;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                if (!writing) begin
                    settle();
                    snd_steady = ($urandom_range(0, 2) == 0);
                    rcv_steady = ($urandom_range(0, 2) == 0);
                    writing = 1'b1;
                end
                write_reg(directed_rows[i].reg_idx, directed_rows[i].wdata);
            end else begin
                if (writing) begin
                    end_writes();
                    writing = 1'b0;
                end
                send_sample(directed_rows[i].innov, directed_rows[i].last,
                            directed_rows[i].kind == ROW_CHECKED, directed_rows[i].known);
            end
        end

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            settle();
            stable = ($urandom_range(0, 1) != 0);
            write_reg(CFG_BASE_VARIANCE, CFG_DATA_W'(
                      stable ? $urandom_range(0, 'h2_0000) : $urandom_range(0, 'hFF_FFFF)));
            write_reg(CFG_ARCH_COEF_ONE, CFG_DATA_W'(
                      stable ? $urandom_range(0, 'h3000) : $urandom_range(0, 'hFFFF)));
            write_reg(CFG_ARCH_COEF_TWO, CFG_DATA_W'(
                      stable ? $urandom_range(0, 'h2000) : $urandom_range(0, 'hFFFF)));
            write_reg(CFG_GARCH_COEF_ONE, CFG_DATA_W'(
                      stable ? $urandom_range(0, 'hC000) : $urandom_range(0, 'hFFFF)));
            write_reg(CFG_GARCH_COEF_TWO, CFG_DATA_W'(
                      stable ? $urandom_range(0, 'h2000) : $urandom_range(0, 'hFFFF)));
            write_reg(CFG_ARCH_ORDER, CFG_DATA_W'($urandom_range(0, 3)));
            write_reg(CFG_GARCH_ORDER, CFG_DATA_W'($urandom_range(0, 3)));
            write_reg(CFG_WARMUP_LENGTH, CFG_DATA_W'(
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4)));
            end_writes();
            snd_steady = ($urandom_range(0, 3) == 0);
            rcv_steady = ($urandom_range(0, 3) == 0);
            runs = $urandom_range(1, 3);
            for (int r = 0; r < runs; r++) begin
                run_len   = $urandom_range(1, 60);
                // Now and then a run stays open across the next register update.
                close_run = (r != runs - 1) || ($urandom_range(0, 4) != 0);
                for (int k = 0; k < run_len; k++) begin
                    send_sample(draw_innovation(), close_run && (k == run_len - 1), 1'b0, '0);
                    random_sent++;
                end
            end
        end

        settle();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned   gap;
        garch_result_t want;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = rcv_steady ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge aclk);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected transfer, expected none actual tdata %0h tlast %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("process_value", want.value, m_tdata[VALUE_W-1:0]);
                check_field("variance_value", want.variance,
                            m_tdata[VALUE_W+VAR_W-1:VALUE_W]);
                check_field("padding", 0, m_tdata[M_TDATA_W-1:VALUE_W+VAR_W]);
                check_field("final_value", want.last, m_tlast);
            end
        end
    end

    initial begin : watchdog
        #(20_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
